// ===== design/dmr_pkg.sv =====
// Package with the shared types, codes and constants of the dual motor ramp drive.
package dmr_pkg;

    localparam int SPEED_W  = 11;
    localparam int GOAL_W   = 12;
    localparam int DUTY_W   = 10;
    localparam int STEP_W   = 10;
    localparam int PERIOD_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic signed [SPEED_W-1:0] FULL_SCALE = 11'sd1023;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TARGETS = 2'd1;
    localparam logic [1:0] OP_ESTOP   = 2'd2;
    localparam logic [1:0] OP_STANDBY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 2'd2;

    localparam logic [STEP_W-1:0]   RAMP_STEP_RST     = 10'd20;
    localparam logic [STEP_W-1:0]   DEAD_BAND_RST     = 10'd10;
    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 8'd10;

    // Bridge pin codes: bit 0 is in1, bit 1 is in2.
    localparam logic [1:0] PINS_BRAKE = 2'b11;
    localparam logic [1:0] PINS_FWD   = 2'b01;
    localparam logic [1:0] PINS_REV   = 2'b10;

    typedef struct packed {
        logic [1:0]        pins;
        logic [DUTY_W-1:0] duty;
    } t_drive;

    // Clamps a 12-bit signed goal to plus or minus full scale.
    function automatic logic signed [SPEED_W-1:0] clamp_goal(
        input logic signed [GOAL_W-1:0] goal
    );
        logic signed [GOAL_W-1:0] hi;
        logic signed [GOAL_W-1:0] lo;
        hi = GOAL_W'(FULL_SCALE);
        lo = -hi;
        if (goal > hi) begin
            return FULL_SCALE;
        end else if (goal < lo) begin
            return -FULL_SCALE;
        end else begin
            return goal[SPEED_W-1:0];
        end
    endfunction

endpackage

// ===== design/dmr_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface dmr_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          op;
    logic signed [dmr_pkg::GOAL_W-1:0]   left_goal;
    logic signed [dmr_pkg::GOAL_W-1:0]   right_goal;
    logic                                standby_request;

    modport source (output valid, op, left_goal, right_goal, standby_request, input ready);
    modport sink   (input valid, op, left_goal, right_goal, standby_request, output ready);
endinterface

interface dmr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                left_in1;
    logic                                left_in2;
    logic [dmr_pkg::DUTY_W-1:0]          left_duty;
    logic                                right_in1;
    logic                                right_in2;
    logic [dmr_pkg::DUTY_W-1:0]          right_duty;
    logic                                enable_pin;
    logic signed [dmr_pkg::SPEED_W-1:0]  left_speed;
    logic signed [dmr_pkg::SPEED_W-1:0]  right_speed;

    modport source (output valid, left_in1, left_in2, left_duty, right_in1, right_in2,
                    right_duty, enable_pin, left_speed, right_speed, input ready);
    modport sink   (input valid, left_in1, left_in2, left_duty, right_in1, right_in2,
                    right_duty, enable_pin, left_speed, right_speed, output ready);
endinterface

interface dmr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dmr_pkg::CFG_IDX_W-1:0]       index;
    logic [dmr_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/dmr_chan.sv =====
// One channel: slew-limited ramp step toward the target and the H-bridge drive decision.
module dmr_chan (
    input  logic signed [dmr_pkg::SPEED_W-1:0] i_now,
    input  logic signed [dmr_pkg::SPEED_W-1:0] i_target,
    input  logic [dmr_pkg::STEP_W-1:0]         i_ramp_step,
    input  logic [dmr_pkg::DUTY_W-1:0]         i_dead_band,
    output logic signed [dmr_pkg::SPEED_W-1:0] o_now,
    output dmr_pkg::t_drive                    o_drive
);

    logic signed [dmr_pkg::GOAL_W-1:0] delta;
    logic [dmr_pkg::GOAL_W-1:0]        delta_mag;
    logic signed [dmr_pkg::SPEED_W-1:0] step_s;
    logic signed [dmr_pkg::SPEED_W-1:0] now_next;
    logic [dmr_pkg::SPEED_W-1:0]        speed_mag;

    always_comb begin
        delta     = dmr_pkg::GOAL_W'(i_target) - dmr_pkg::GOAL_W'(i_now);
        delta_mag = delta[dmr_pkg::GOAL_W-1] ? dmr_pkg::GOAL_W'(-delta) : delta;
        step_s    = {1'b0, i_ramp_step};

        // Snap to the target once it is closer than one step.
        if (delta_mag < dmr_pkg::GOAL_W'(step_s)) begin
            now_next = i_target;
        end else if (delta > 0) begin
            now_next = i_now + step_s;
        end else begin
            now_next = i_now - step_s;
        end

        speed_mag = now_next[dmr_pkg::SPEED_W-1] ? dmr_pkg::SPEED_W'(-now_next) : now_next;

        if (speed_mag[dmr_pkg::DUTY_W-1:0] <= i_dead_band) begin
            o_drive.pins = dmr_pkg::PINS_BRAKE;
            o_drive.duty = '0;
        end else begin
            o_drive.pins = (now_next > 0) ? dmr_pkg::PINS_FWD : dmr_pkg::PINS_REV;
            o_drive.duty = speed_mag[dmr_pkg::DUTY_W-1:0];
        end
        o_now = now_next;
    end

endmodule

// ===== design/dual_motor_ramp_hbridge_drive_core.sv =====
// Two-channel slew-rate limited motor drive with H-bridge pin and duty outputs.
// Each accepted item (tick, set targets, emergency stop, standby) is handled by a
// compare-and-add per channel; its result is the drive state after the item, held in
// the state registers themselves, and a new item is accepted in every cycle in which the
// result slot is empty or being taken. Throughput is one item per cycle while results
// are taken; a result is valid in the cycle after its item is accepted. Configuration
// writes are always accepted and should be made only while the block is idle.
module dual_motor_ramp_hbridge_drive_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmr_in_if.sink     i_in,
    dmr_out_if.source  o_out,
    dmr_cfg_if.sink    i_cfg
);

    logic [dmr_pkg::STEP_W-1:0]   r_ramp_step;
    logic [dmr_pkg::DUTY_W-1:0]   r_dead_band;
    logic [dmr_pkg::PERIOD_W-1:0] r_period;

    logic signed [dmr_pkg::SPEED_W-1:0] r_left_target, n_left_target;
    logic signed [dmr_pkg::SPEED_W-1:0] r_right_target, n_right_target;
    logic signed [dmr_pkg::SPEED_W-1:0] r_left_now, n_left_now;
    logic signed [dmr_pkg::SPEED_W-1:0] r_right_now, n_right_now;
    logic                               r_standby, n_standby;
    logic [dmr_pkg::PERIOD_W-1:0]       r_ms, n_ms;
    dmr_pkg::t_drive                    r_left_drv, n_left_drv;
    dmr_pkg::t_drive                    r_right_drv, n_right_drv;
    logic                               r_out_valid;

    logic signed [dmr_pkg::SPEED_W-1:0] left_ramped, right_ramped;
    dmr_pkg::t_drive                    left_drv_calc, right_drv_calc;
    logic [dmr_pkg::PERIOD_W:0]         ms_inc;
    logic                               in_fire;

    dmr_chan u_left (
        .i_now       (r_left_now),
        .i_target    (r_left_target),
        .i_ramp_step (r_ramp_step),
        .i_dead_band (r_dead_band),
        .o_now       (left_ramped),
        .o_drive     (left_drv_calc)
    );

    dmr_chan u_right (
        .i_now       (r_right_now),
        .i_target    (r_right_target),
        .i_ramp_step (r_ramp_step),
        .i_dead_band (r_dead_band),
        .o_now       (right_ramped),
        .o_drive     (right_drv_calc)
    );

    // The state only moves on an accepted item, so a waiting result stays put.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_left_target  = r_left_target;
        n_right_target = r_right_target;
        n_left_now     = r_left_now;
        n_right_now    = r_right_now;
        n_standby      = r_standby;
        n_ms           = r_ms;
        n_left_drv     = r_left_drv;
        n_right_drv    = r_right_drv;
        ms_inc         = {1'b0, r_ms} + 1'b1;

        case (i_in.op)
            dmr_pkg::OP_TICK: begin
                if (ms_inc >= {1'b0, r_period}) begin
                    n_ms = '0;
                    if (r_standby) begin
                        n_left_now  = '0;
                        n_right_now = '0;
                    end else begin
                        n_left_now  = left_ramped;
                        n_right_now = right_ramped;
                        n_left_drv  = left_drv_calc;
                        n_right_drv = right_drv_calc;
                    end
                end else begin
                    n_ms = ms_inc[dmr_pkg::PERIOD_W-1:0];
                end
            end
            dmr_pkg::OP_TARGETS: begin
                n_left_target  = dmr_pkg::clamp_goal(i_in.left_goal);
                n_right_target = dmr_pkg::clamp_goal(i_in.right_goal);
            end
            dmr_pkg::OP_ESTOP: begin
                n_left_target    = '0;
                n_right_target   = '0;
                n_left_now       = '0;
                n_right_now      = '0;
                n_left_drv.pins  = dmr_pkg::PINS_BRAKE;
                n_left_drv.duty  = '0;
                n_right_drv.pins = dmr_pkg::PINS_BRAKE;
                n_right_drv.duty = '0;
                n_standby        = 1'b1;
            end
            dmr_pkg::OP_STANDBY: begin
                n_standby = i_in.standby_request;
            end
            default: begin
                n_standby = r_standby;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step <= dmr_pkg::RAMP_STEP_RST;
            r_dead_band <= dmr_pkg::DEAD_BAND_RST;
            r_period    <= dmr_pkg::UPDATE_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dmr_pkg::CFG_RAMP_STEP:     r_ramp_step <= i_cfg.data;
                dmr_pkg::CFG_DEAD_BAND:     r_dead_band <= i_cfg.data;
                dmr_pkg::CFG_UPDATE_PERIOD: r_period    <= i_cfg.data[dmr_pkg::PERIOD_W-1:0];
                default: begin
                    r_period <= r_period;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_target  <= '0;
            r_right_target <= '0;
            r_left_now     <= '0;
            r_right_now    <= '0;
            r_standby      <= 1'b1;
            r_ms           <= '0;
            r_left_drv     <= '{pins: dmr_pkg::PINS_BRAKE, duty: '0};
            r_right_drv    <= '{pins: dmr_pkg::PINS_BRAKE, duty: '0};
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_left_target  <= n_left_target;
                r_right_target <= n_right_target;
                r_left_now     <= n_left_now;
                r_right_now    <= n_right_now;
                r_standby      <= n_standby;
                r_ms           <= n_ms;
                r_left_drv     <= n_left_drv;
                r_right_drv    <= n_right_drv;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_in1    = r_left_drv.pins[0];
    assign o_out.left_in2    = r_left_drv.pins[1];
    assign o_out.left_duty   = r_left_drv.duty;
    assign o_out.right_in1   = r_right_drv.pins[0];
    assign o_out.right_in2   = r_right_drv.pins[1];
    assign o_out.right_duty  = r_right_drv.duty;
    assign o_out.enable_pin  = !r_standby;
    assign o_out.left_speed  = r_left_now;
    assign o_out.right_speed = r_right_now;

`ifndef SYNTHESIS
    // An emergency stop leaves both speeds at zero and the block in standby.
    a_estop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == dmr_pkg::OP_ESTOP)
        |=> (r_left_now == '0 && r_right_now == '0 && r_standby))
        else $error("emergency stop did not clear the drive");

    // A braking bridge never carries a nonzero duty.
    a_brake_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_left_drv.pins != dmr_pkg::PINS_BRAKE || r_left_drv.duty == '0) &&
         (r_right_drv.pins != dmr_pkg::PINS_BRAKE || r_right_drv.duty == '0)))
        else $error("brake with nonzero duty");

    // Speeds stay within full scale; this check covers the lower bound.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_now >= -dmr_pkg::FULL_SCALE && r_right_now >= -dmr_pkg::FULL_SCALE))
        else $error("speed out of range");

    // A result that is not taken keeps the state unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready)
        |=> ($stable(r_left_now) && $stable(r_right_now) && $stable(r_standby)))
        else $error("state moved while a result was waiting");
`endif

endmodule

// ===== tb/dmr_drive_checker.sv =====
`timescale 1ns / 1ps
// Watches the drive channels, predicts every result item and compares it field by field.
module dmr_drive_checker
    import dmr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dmr_in_if    i_in,
    dmr_out_if   i_out,
    dmr_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_waiting,
    output int   o_checked,
    output int   o_ramp_updates
);

    typedef struct {
        logic                      left_in1;
        logic                      left_in2;
        logic [DUTY_W-1:0]         left_duty;
        logic                      right_in1;
        logic                      right_in2;
        logic [DUTY_W-1:0]         right_duty;
        logic                      enable_pin;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } t_drive_view;

    logic [STEP_W-1:0]         ramp_step_q;
    logic [STEP_W-1:0]         dead_band_q;
    logic [PERIOD_W-1:0]       update_period_q;

    logic signed [SPEED_W-1:0] left_goal_q;
    logic signed [SPEED_W-1:0] right_goal_q;
    logic signed [SPEED_W-1:0] left_speed_q;
    logic signed [SPEED_W-1:0] right_speed_q;
    logic                      standby_q;
    logic [PERIOD_W-1:0]       ms_count_q;
    t_drive                    left_bridge_q;
    t_drive                    right_bridge_q;

    t_drive_view               drive_expected[$];
    int                        mismatches = 0;
    int                        waiting_n = 0;
    int                        checked_n = 0;
    int                        updates_n = 0;

    assign o_fail_count   = mismatches;
    assign o_waiting      = waiting_n;
    assign o_checked      = checked_n;
    assign o_ramp_updates = updates_n;

    function automatic logic signed [SPEED_W-1:0] limit_goal(
        input logic signed [GOAL_W-1:0] goal
    );
        int v;
        int full;
        v = int'(goal);
        full = int'(FULL_SCALE);
        if (v > full) begin
            v = full;
        end else if (v < -full) begin
            v = -full;
        end
        return SPEED_W'(v);
    endfunction

    // Moves one step toward the goal, or lands on it when it is closer than a step.
    function automatic logic signed [SPEED_W-1:0] slew_toward(
        input logic signed [SPEED_W-1:0] now,
        input logic signed [SPEED_W-1:0] goal
    );
        int diff;
        int mag;
        int stride;
        diff = int'(goal) - int'(now);
        mag = (diff < 0) ? -diff : diff;
        stride = int'(ramp_step_q);
        if (mag < stride) begin
            return goal;
        end
        return SPEED_W'((diff > 0) ? int'(now) + stride : int'(now) - stride);
    endfunction

    function automatic t_drive bridge_for(input logic signed [SPEED_W-1:0] speed);
        int     mag;
        t_drive d;
        mag = int'(speed);
        if (mag < 0) begin
            mag = -mag;
        end
        if (mag <= int'(dead_band_q)) begin
            d.pins = PINS_BRAKE;
            d.duty = '0;
        end else begin
            d.pins = (speed > 0) ? PINS_FWD : PINS_REV;
            d.duty = DUTY_W'(mag);
        end
        return d;
    endfunction

    task automatic run_ramp_update();
        if (standby_q) begin
            left_speed_q  = '0;
            right_speed_q = '0;
        end else begin
            left_speed_q   = slew_toward(left_speed_q, left_goal_q);
            right_speed_q  = slew_toward(right_speed_q, right_goal_q);
            left_bridge_q  = bridge_for(left_speed_q);
            right_bridge_q = bridge_for(right_speed_q);
            updates_n++;
        end
    endtask

    task automatic apply_drive_item(
        input  logic [1:0]              op,
        input  logic signed [GOAL_W-1:0] left_goal,
        input  logic signed [GOAL_W-1:0] right_goal,
        input  logic                    standby_request,
        output t_drive_view             view
    );
        int next_count;
        case (op)
            OP_TICK: begin
                next_count = int'(ms_count_q) + 1;
                if (next_count >= int'(update_period_q)) begin
                    ms_count_q = '0;
                    run_ramp_update();
                end else begin
                    ms_count_q = PERIOD_W'(next_count);
                end
            end
            OP_TARGETS: begin
                left_goal_q  = limit_goal(left_goal);
                right_goal_q = limit_goal(right_goal);
            end
            OP_ESTOP: begin
                left_goal_q    = '0;
                right_goal_q   = '0;
                left_speed_q   = '0;
                right_speed_q  = '0;
                left_bridge_q  = '{pins: PINS_BRAKE, duty: '0};
                right_bridge_q = '{pins: PINS_BRAKE, duty: '0};
                standby_q      = 1'b1;
            end
            default: begin
                standby_q = standby_request;
            end
        endcase
        view.left_in1    = left_bridge_q.pins[0];
        view.left_in2    = left_bridge_q.pins[1];
        view.left_duty   = left_bridge_q.duty;
        view.right_in1   = right_bridge_q.pins[0];
        view.right_in2   = right_bridge_q.pins[1];
        view.right_duty  = right_bridge_q.duty;
        view.enable_pin  = !standby_q;
        view.left_speed  = left_speed_q;
        view.right_speed = right_speed_q;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_view want;
        if (!i_rst_n) begin
            ramp_step_q     = RAMP_STEP_RST;
            dead_band_q     = DEAD_BAND_RST;
            update_period_q = UPDATE_PERIOD_RST;
            left_goal_q     = '0;
            right_goal_q    = '0;
            left_speed_q    = '0;
            right_speed_q   = '0;
            standby_q       = 1'b1;
            ms_count_q      = '0;
            left_bridge_q   = '{pins: PINS_BRAKE, duty: '0};
            right_bridge_q  = '{pins: PINS_BRAKE, duty: '0};
            drive_expected.delete();
        end else begin
            // The result taken at this edge belongs to an item accepted earlier,
            // so it is compared before this edge's item is predicted.
            if (i_out.valid && i_out.ready) begin
                if (drive_expected.size() == 0) begin
                    $error("result item arrived with no item waiting for it");
                    mismatches++;
                end else begin
                    want = drive_expected.pop_front();
                    check_field("left_in1", int'(want.left_in1), int'(i_out.left_in1));
                    check_field("left_in2", int'(want.left_in2), int'(i_out.left_in2));
                    check_field("left_duty", int'(want.left_duty), int'(i_out.left_duty));
                    check_field("right_in1", int'(want.right_in1), int'(i_out.right_in1));
                    check_field("right_in2", int'(want.right_in2), int'(i_out.right_in2));
                    check_field("right_duty", int'(want.right_duty),
                                int'(i_out.right_duty));
                    check_field("enable_pin", int'(want.enable_pin),
                                int'(i_out.enable_pin));
                    check_field("left_speed", int'(want.left_speed), int'(i_out.left_speed));
                    check_field("right_speed", int'(want.right_speed),
                                int'(i_out.right_speed));
                    checked_n++;
                end
            end
            if (i_in.valid && i_in.ready) begin
                apply_drive_item(i_in.op, i_in.left_goal, i_in.right_goal,
                                 i_in.standby_request, want);
                drive_expected.push_back(want);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_RAMP_STEP:     ramp_step_q     = i_cfg.data[STEP_W-1:0];
                    CFG_DEAD_BAND:     dead_band_q     = i_cfg.data[STEP_W-1:0];
                    CFG_UPDATE_PERIOD: update_period_q = i_cfg.data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
        waiting_n = drive_expected.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the drive testbench: clock, reset, stimulus, result back-pressure and verdict.
module testbench;
    import dmr_pkg::*;

    // Index that selects no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 170;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dmr_in_if  in_ch();
    dmr_out_if out_ch();
    dmr_cfg_if cfg_ch();

    int fail_count;
    int waiting;
    int checked;
    int ramp_updates;

    int sender_idle_pct = 15;
    int receiver_idle_pct = 55;
    int hold_request = 0;
    int items_sent = 0;
    int settings_used = 0;

    dual_motor_ramp_hbridge_drive_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    dmr_drive_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .i_cfg          (cfg_ch),
        .o_fail_count   (fail_count),
        .o_waiting      (waiting),
        .o_checked      (checked),
        .o_ramp_updates (ramp_updates)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #2_400_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer(
        input logic [1:0]               op,
        input logic signed [GOAL_W-1:0] left_goal,
        input logic signed [GOAL_W-1:0] right_goal,
        input logic                     standby_request
    );
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.op              <= op;
        in_ch.left_goal       <= left_goal;
        in_ch.right_goal      <= right_goal;
        in_ch.standby_request <= standby_request;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (waiting != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_drive(
        input logic [CFG_DATA_W-1:0] step,
        input logic [CFG_DATA_W-1:0] band,
        input logic [CFG_DATA_W-1:0] period
    );
        write_register(CFG_RAMP_STEP, step);
        write_register(CFG_DEAD_BAND, band);
        write_register(CFG_UPDATE_PERIOD, period);
        settings_used++;
    endtask

    function automatic logic signed [GOAL_W-1:0] pick_goal();
        int k;
        int v;
        k = $urandom_range(9);
        if (k < 6) begin
            v = $urandom_range(2046);
            v -= 1023;
        end else if (k < 8) begin
            v = $urandom;
        end else if (k == 8) begin
            case ($urandom_range(2))
                0: v = 1023;
                1: v = -1023;
                default: v = 0;
            endcase
        end else begin
            // Small speeds that sit around the brake band.
            v = $urandom_range(80);
            v -= 40;
        end
        return GOAL_W'(v);
    endfunction

    // Mostly ticks so the ramps actually travel; the rest retargets, toggles
    // standby (mostly leaving it) and now and then stops the drive.
    task automatic send_random();
        int          r;
        logic [1:0]  op;
        r = $urandom_range(99);
        if (r < 66) begin
            op = OP_TICK;
        end else if (r < 84) begin
            op = OP_TARGETS;
        end else if (r < 96) begin
            op = OP_STANDBY;
        end else begin
            op = OP_ESTOP;
        end
        offer(op, pick_goal(), pick_goal(), $urandom_range(99) < 25);
    endtask

    initial begin : stimulus
        in_ch.valid           = 1'b0;
        in_ch.op              = OP_TICK;
        in_ch.left_goal       = '0;
        in_ch.right_goal      = '0;
        in_ch.standby_request = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_RAMP_STEP;
        cfg_ch.data           = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset settings: clamped targets stored in standby,
        // a ramp update that only zeroes speeds, and leaving standby with pins held.
        offer(OP_TARGETS, 12'sd2047, -12'sd2048, 1'b0);
        repeat (10) offer(OP_TICK, '0, '0, 1'b0);
        offer(OP_STANDBY, '0, '0, 1'b0);
        drain();
        // A zero update period makes every tick run the ramp.
        write_register(CFG_UPDATE_PERIOD, '0);
        repeat (3) offer(OP_TICK, '0, '0, 1'b0);
        offer(OP_TARGETS, 12'sd1024, -12'sd1024, 1'b0);
        offer(OP_TARGETS, 12'sd5, -12'sd3, 1'b0);
        repeat (4) offer(OP_TICK, '0, '0, 1'b0);
        offer(OP_TARGETS, -12'sd1023, 12'sd1023, 1'b1);
        offer(OP_TICK, '0, '0, 1'b0);
        offer(OP_ESTOP, 12'sd100, 12'sd100, 1'b0);
        offer(OP_STANDBY, '0, '0, 1'b1);
        offer(OP_TICK, '0, '0, 1'b0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                sender_idle_pct   = 15;
                receiver_idle_pct = 55;
            end else if (phase < 6) begin
                sender_idle_pct   = 55;
                receiver_idle_pct = 15;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (phase)
                0: set_drive(10'd20, 10'd10, 10'd10);
                1: set_drive(10'd1, 10'd0, 10'd1);
                2: set_drive(10'd1023, 10'd1023, 10'd2);
                3: set_drive(10'd0, 10'd5, 10'd0);
                4: set_drive(CFG_DATA_W'($urandom_range(1, 1023)),
                             CFG_DATA_W'($urandom_range(200)), 10'h105);
                5: set_drive(10'h2AA, 10'h155, 10'h3FF);
                6: set_drive(10'd7, 10'd3, 10'h303);
                7: set_drive(10'd64, 10'd20, 10'd4);
                default: begin
                    set_drive(CFG_DATA_W'($urandom_range(1, 1023)),
                              CFG_DATA_W'($urandom_range(100)),
                              CFG_DATA_W'($urandom_range(1, 6)));
                    write_register(CFG_UNUSED, 10'h3FF);
                end
            endcase
            // Each phase opens with a well-formed start: leave standby, set targets.
            offer(OP_STANDBY, '0, '0, 1'b0);
            offer(OP_TARGETS, pick_goal(), pick_goal(), 1'b0);
            for (int n = 2; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == 50) begin
                    hold_request = 40;
                end
                send_random();
            end
            drain();
        end

        if (waiting != 0) begin
            $error("%0d expected result items never arrived", waiting);
        end
        $display("Sent %0d items across %0d drive settings and checked %0d results.",
                 items_sent, settings_used, checked);
        $display("The ramp stepped outside standby %0d times.", ramp_updates);
        if (fail_count == 0 && waiting == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dmr_pkg.sv
design/dmr_if.sv
design/dmr_chan.sv
design/dual_motor_ramp_hbridge_drive_core.sv
tb/dmr_drive_checker.sv
tb/testbench.sv
